/* hdl/tkpr_pkg.sv */
// Shared types and constants for the top-k pixel ranker.
package tkpr_pkg;

  localparam int DEF_RANK_DEPTH = 16;

  localparam int VAL_W   = 16;
  localparam int COORD_W = 12;
  localparam int RIDX_W  = 4;
  localparam int RANK_W  = 5;
  localparam int TOTAL_W = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0]   val;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the operands of an accepted transfer
    logic exec;  // carry out the captured command
  } ctl_cmd_t;

endpackage

/* hdl/tkpr_ctrl.sv */
// Controller for the top-k pixel ranker: sequencing and handshake.
module tkpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output tkpr_pkg::ctl_cmd_t cmd_o
);
  import tkpr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

/* hdl/tkpr_datapath.sv */
// Datapath for the top-k pixel ranker: ranked cell row, counters, result registers.
module tkpr_datapath #(
  parameter int RANK_DEPTH = tkpr_pkg::DEF_RANK_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tkpr_pkg::ctl_cmd_t           cmd_i,
  input  logic                         command_i,
  input  logic [tkpr_pkg::VAL_W-1:0]   pixel_value_i,
  input  logic [tkpr_pkg::COORD_W-1:0] pixel_column_i,
  input  logic [tkpr_pkg::COORD_W-1:0] pixel_row_i,
  input  logic [tkpr_pkg::RIDX_W-1:0]  read_index_i,
  output logic [tkpr_pkg::RANK_W-1:0]  landed_rank_o,
  output logic [tkpr_pkg::RANK_W-1:0]  filled_entries_o,
  output logic [tkpr_pkg::TOTAL_W-1:0] pixel_total_o,
  output logic [tkpr_pkg::VAL_W-1:0]   entry_value_o,
  output logic [tkpr_pkg::COORD_W-1:0] entry_column_o,
  output logic [tkpr_pkg::COORD_W-1:0] entry_row_o,
  output logic                         entry_valid_o
);
  import tkpr_pkg::*;

  localparam int CNT_W = $clog2(RANK_DEPTH + 1);

  // captured operands
  logic               op_cmd_q;
  entry_t             op_pix_q;
  logic [RIDX_W-1:0]  op_idx_q;

  // ranked cells, descending by value; contents beyond the fill count are don't-care
  entry_t             cell_q [RANK_DEPTH];
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // result registers
  logic [RANK_W-1:0]  landed_q, landed_d;
  entry_t             rd_q, rd_d;
  logic               valid_q, valid_d;

  logic [RANK_DEPTH-1:0] ge;   // cell holds a value at least as large (prefix mask)
  logic [RANK_DEPTH-1:0] ins;  // one-hot insertion point
  logic [CNT_W-1:0]      pos;
  logic                  do_push;
  entry_t                rd_sel;

  assign do_push = cmd_i.exec && (op_cmd_q == CMD_PUSH);

  always_comb begin
    for (int k = 0; k < RANK_DEPTH; k++) begin
      ge[k] = (CNT_W'(k) < fill_q) && (cell_q[k].val >= op_pix_q.val);
    end
    for (int k = 0; k < RANK_DEPTH; k++) begin
      if (k == 0) begin
        ins[k] = !ge[k];
      end else begin
        ins[k] = !ge[k] && ge[k-1];
      end
    end
    pos = '0;
    for (int k = 0; k < RANK_DEPTH; k++) begin
      if (ins[k]) begin
        pos = pos | CNT_W'(k);
      end
    end
    if (!(|ins)) begin
      pos = CNT_W'(RANK_DEPTH);
    end
  end

  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < RANK_DEPTH; k++) begin
      if (int'(op_idx_q) == k) begin
        rd_sel = cell_q[k];
      end
    end
  end

  always_comb begin
    fill_d   = fill_q;
    total_d  = total_q;
    landed_d = landed_q;
    rd_d     = rd_q;
    valid_d  = valid_q;
    if (cmd_i.exec) begin
      if (op_cmd_q == CMD_PUSH) begin
        if ((|ins) && (fill_q < CNT_W'(RANK_DEPTH))) begin
          fill_d = fill_q + 1'b1;
        end
        total_d  = total_q + 1'b1;
        landed_d = RANK_W'(pos);
        rd_d     = '0;
        valid_d  = 1'b0;
      end else begin
        landed_d = '0;
        if (int'(op_idx_q) < int'(fill_q)) begin
          rd_d    = rd_sel;
          valid_d = 1'b1;
        end else begin
          rd_d    = '0;
          valid_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_cmd_q     <= command_i;
      op_pix_q.val <= pixel_value_i;
      op_pix_q.col <= pixel_column_i;
      op_pix_q.row <= pixel_row_i;
      op_idx_q     <= read_index_i;
    end
    landed_q <= landed_d;
    rd_q     <= rd_d;
    valid_q  <= valid_d;
  end

  // each cell takes the new pixel, shifts down from the cell above, or holds
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      for (int k = 0; k < RANK_DEPTH; k++) begin
        if (ins[k]) begin
          cell_q[k] <= op_pix_q;
        end else if (k > 0) begin
          if (!ge[k-1]) begin
            cell_q[k] <= cell_q[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  assign landed_rank_o    = landed_q;
  assign filled_entries_o = RANK_W'(fill_q);
  assign pixel_total_o    = total_q;
  assign entry_value_o    = rd_q.val;
  assign entry_column_o   = rd_q.col;
  assign entry_row_o      = rd_q.row;
  assign entry_valid_o    = valid_q;

endmodule

/* hdl/top_k_pixel_ranker.sv */
// Top level of the top-k pixel ranker.
// Keeps the RANK_DEPTH largest pixels pushed since reset in descending order; ties keep the
// earlier pixel higher. A command is taken when start is high and busy is low; every command
// runs as a capture step, then one parallel compare-and-shift over the cell row; busy stays
// high until it is through, so no new command is accepted before then. The result appears in
// the same cycle that busy falls, on the result ports with done_o high for one cycle; there is
// no back-pressure, so the receiver must take it then.
module top_k_pixel_ranker #(
  parameter int RANK_DEPTH = tkpr_pkg::DEF_RANK_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [tkpr_pkg::VAL_W-1:0]   pixel_value_i,
  input  logic [tkpr_pkg::COORD_W-1:0] pixel_column_i,
  input  logic [tkpr_pkg::COORD_W-1:0] pixel_row_i,
  input  logic [tkpr_pkg::RIDX_W-1:0]  read_index_i,
  output logic                         done_o,
  output logic [tkpr_pkg::RANK_W-1:0]  landed_rank_o,
  output logic [tkpr_pkg::RANK_W-1:0]  filled_entries_o,
  output logic [tkpr_pkg::TOTAL_W-1:0] pixel_total_o,
  output logic [tkpr_pkg::VAL_W-1:0]   entry_value_o,
  output logic [tkpr_pkg::COORD_W-1:0] entry_column_o,
  output logic [tkpr_pkg::COORD_W-1:0] entry_row_o,
  output logic                         entry_valid_o
);
  import tkpr_pkg::*;

  ctl_cmd_t ctl_cmd;

  tkpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (ctl_cmd)
  );

  tkpr_datapath #(
    .RANK_DEPTH (RANK_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctl_cmd),
    .command_i        (command_i),
    .pixel_value_i    (pixel_value_i),
    .pixel_column_i   (pixel_column_i),
    .pixel_row_i      (pixel_row_i),
    .read_index_i     (read_index_i),
    .landed_rank_o    (landed_rank_o),
    .filled_entries_o (filled_entries_o),
    .pixel_total_o    (pixel_total_o),
    .entry_value_o    (entry_value_o),
    .entry_column_o   (entry_column_o),
    .entry_row_o      (entry_row_o),
    .entry_valid_o    (entry_valid_o)
  );

endmodule
